// ===== sv/ppr_pkg.sv =====
// ----------------------------------------------------------------------------
// ppr_pkg: shared types and constants of the point projector
// Stage payload structs, field widths and configuration register indexes.
// ----------------------------------------------------------------------------
package ppr_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_FOCAL  = 3'd0,
    CFG_WIDTH  = 3'd1,
    CFG_HEIGHT = 3'd2,
    CFG_FAR    = 3'd3,
    CFG_NEAR   = 3'd4
  } cfg_idx_e;

  localparam int unsigned MaxImageSide = 256;
  localparam int unsigned CoordW = 32;
  localparam int unsigned FocalW = 20;
  localparam int unsigned SideW  = 9;
  localparam int unsigned DistW  = 20;
  localparam int unsigned CfgW   = 20;
  localparam int unsigned PixW   = 8;
  // remainder of the projection divide, divisor is 512*z
  localparam int unsigned RemW   = 56;
  localparam int unsigned DenW   = 40;
  // quotient bits for the largest supported image side
  localparam int unsigned QuoW   = 13;
  // gray search: scaled far, squared terms
  localparam int unsigned GrayW  = 8;
  localparam int unsigned SpanW  = 28;
  localparam int unsigned SqW    = 56;

  typedef struct packed {
    logic vld;
    logic last;
    logic ok;
    logic inband;
  } ctrl_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [DenW-1:0] den;
    logic [QuoW-1:0] quo;
    logic            neg;
    logic            over;
  } axis_t;

  typedef struct packed {
    logic [SqW-1:0]   lhs;
    logic [SpanW-1:0] gdd;
    logic [GrayW-1:0] lvl;
  } gray_t;

  typedef struct packed {
    ctrl_t ctrl;
    axis_t ax;
    axis_t ay;
    gray_t gr;
  } stage_t;

endpackage

// ===== sv/ppr_front.sv =====
// ----------------------------------------------------------------------------
// ppr_front: projection front end
// Three stages: products, sums, then divide setup and range band check.
// ----------------------------------------------------------------------------
module ppr_front #(
  parameter int unsigned QB = 9
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         take_i,
  input  logic signed [ppr_pkg::CoordW-1:0] point_x_i,
  input  logic signed [ppr_pkg::CoordW-1:0] point_y_i,
  input  logic signed [ppr_pkg::CoordW-1:0] point_z_i,
  input  logic                         point_valid_i,
  input  logic                         frame_last_i,
  input  logic [ppr_pkg::FocalW-1:0]   focal_i,
  input  logic [ppr_pkg::SideW-1:0]    side_w_i,
  input  logic [ppr_pkg::SideW-1:0]    side_h_i,
  input  logic [ppr_pkg::DistW-1:0]    far_i,
  input  logic [ppr_pkg::DistW-1:0]    near_i,
  output ppr_pkg::stage_t              stage_o
);

  // stage 1 registers
  logic              vld1_q, last1_q, ok1_q;
  logic signed [52:0] px1_q, py1_q;
  logic signed [41:0] bw1_q, bh1_q;
  logic [63:0]       sx1_q, sy1_q, sz1_q;
  logic [30:0]       z1_q;
  // stage 2 registers
  logic              vld2_q, last2_q, ok2_q;
  logic signed [53:0] nx2_q, ny2_q;
  logic [63:0]       s2_q;
  logic [30:0]       z2_q;
  // stage 2 sums
  logic signed [53:0] nx2_d, ny2_d;
  logic [63:0]       s2_d;
  // stage 3 setup
  ppr_pkg::stage_t   st3_d, st3_q;
  logic [53:0]       magx, magy;
  logic [ppr_pkg::RemW-1:0] dz, lim;
  logic [39:0]       far_sq, near_sq;

  // stage 1 valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= take_i;
      vld2_q <= vld1_q;
    end
  end

  // stage 1 products
  always_ff @(posedge clk_i) begin
    last1_q <= frame_last_i;
    ok1_q   <= point_valid_i && (point_z_i > 0);
    px1_q   <= $signed({1'b0, focal_i}) * point_x_i;
    py1_q   <= $signed({1'b0, focal_i}) * point_y_i;
    bw1_q   <= $signed({1'b0, side_w_i}) * point_z_i;
    bh1_q   <= $signed({1'b0, side_h_i}) * point_z_i;
    sx1_q   <= 64'(point_x_i * point_x_i);
    sy1_q   <= 64'(point_y_i * point_y_i);
    sz1_q   <= 64'(point_z_i * point_z_i);
    z1_q    <= point_z_i[30:0];
  end

  // stage 2 sums: numerators and squared range
  always_comb begin
    nx2_d = $signed({{5{bw1_q[41]}}, bw1_q[41:0], 7'b0}) + 54'(px1_q);
    ny2_d = $signed({{5{bh1_q[41]}}, bh1_q[41:0], 7'b0}) + 54'(py1_q);
    s2_d  = sx1_q + sy1_q + sz1_q;
  end

  always_ff @(posedge clk_i) begin
    last2_q <= last1_q;
    ok2_q   <= ok1_q;
    nx2_q   <= nx2_d;
    ny2_q   <= ny2_d;
    s2_q    <= s2_d;
    z2_q    <= z1_q;
  end

  // stage 3: magnitude, rounded dividend, overflow and band check
  always_comb begin
    magx    = nx2_q[53] ? 54'(-nx2_q) : 54'(nx2_q);
    magy    = ny2_q[53] ? 54'(-ny2_q) : 54'(ny2_q);
    dz      = ppr_pkg::RemW'({z2_q, 8'b0});
    lim     = ppr_pkg::RemW'({z2_q, 9'b0}) << QB;
    far_sq  = far_i * far_i;
    near_sq = near_i * near_i;
    st3_d   = '0;
    st3_d.ctrl.vld    = vld2_q;
    st3_d.ctrl.last   = last2_q;
    st3_d.ctrl.ok     = ok2_q;
    st3_d.ctrl.inband = (far_i > near_i) && (s2_q <= 64'(far_sq)) &&
                        (s2_q >= 64'(near_sq));
    st3_d.ax.rem  = ppr_pkg::RemW'({magx, 1'b0}) + dz;
    st3_d.ay.rem  = ppr_pkg::RemW'({magy, 1'b0}) + dz;
    st3_d.ax.den  = {z2_q, 9'b0};
    st3_d.ay.den  = {z2_q, 9'b0};
    st3_d.ax.neg  = nx2_q[53];
    st3_d.ay.neg  = ny2_q[53];
    st3_d.ax.over = st3_d.ax.rem >= lim;
    st3_d.ay.over = st3_d.ay.rem >= lim;
    st3_d.gr.lhs  = ppr_pkg::SqW'({s2_q[39:0], 16'b0}) - ppr_pkg::SqW'({s2_q[39:0], 9'b0})
                  + ppr_pkg::SqW'(s2_q[39:0]);
  end

  // stage 3 register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st3_q <= '0;
    end else begin
      st3_q <= st3_d;
    end
  end

  assign stage_o = st3_q;

endmodule

// ===== sv/ppr_cell.sv =====
// ----------------------------------------------------------------------------
// ppr_cell: one cell of the projection chain
// Resolves one quotient bit per axis, one gray level bit or both, as its BIT allows, then hands on.
// ----------------------------------------------------------------------------
module ppr_cell #(
  parameter int unsigned BIT = 0,
  parameter int unsigned QB  = 9
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [ppr_pkg::SpanW-1:0]   span_top_i,
  input  logic [ppr_pkg::DistW-1:0]   span_i,
  input  ppr_pkg::stage_t             prev_i,
  output ppr_pkg::stage_t             next_o
);

  ppr_pkg::stage_t next_d, next_q;

  // restoring divide step and gray search step
  generate
    if ((BIT < QB) && (BIT < ppr_pkg::GrayW)) begin : g_both
      logic [ppr_pkg::RemW-1:0]  trx, try_;
      logic [ppr_pkg::SpanW-1:0] step, tt;
      logic [ppr_pkg::SqW-1:0]   sq;
      always_comb begin
        trx    = ppr_pkg::RemW'(prev_i.ax.den) << BIT;
        try_   = ppr_pkg::RemW'(prev_i.ay.den) << BIT;
        step   = ppr_pkg::SpanW'(span_i) << BIT;
        tt     = span_top_i - prev_i.gr.gdd - step;
        sq     = tt * tt;
        next_d = prev_i;
        if (prev_i.ax.rem >= trx) begin
          next_d.ax.rem      = prev_i.ax.rem - trx;
          next_d.ax.quo[BIT] = 1'b1;
        end
        if (prev_i.ay.rem >= try_) begin
          next_d.ay.rem      = prev_i.ay.rem - try_;
          next_d.ay.quo[BIT] = 1'b1;
        end
        if (sq >= prev_i.gr.lhs) begin
          next_d.gr.gdd      = prev_i.gr.gdd + step;
          next_d.gr.lvl[BIT] = 1'b1;
        end
      end
    end else if (BIT < QB) begin : g_div
      logic [ppr_pkg::RemW-1:0] trx, try_;
      always_comb begin
        trx    = ppr_pkg::RemW'(prev_i.ax.den) << BIT;
        try_   = ppr_pkg::RemW'(prev_i.ay.den) << BIT;
        next_d = prev_i;
        if (prev_i.ax.rem >= trx) begin
          next_d.ax.rem      = prev_i.ax.rem - trx;
          next_d.ax.quo[BIT] = 1'b1;
        end
        if (prev_i.ay.rem >= try_) begin
          next_d.ay.rem      = prev_i.ay.rem - try_;
          next_d.ay.quo[BIT] = 1'b1;
        end
      end
    end else begin : g_gray
      logic [ppr_pkg::SpanW-1:0] step, tt;
      logic [ppr_pkg::SqW-1:0]   sq;
      always_comb begin
        step   = ppr_pkg::SpanW'(span_i) << BIT;
        tt     = span_top_i - prev_i.gr.gdd - step;
        sq     = tt * tt;
        next_d = prev_i;
        if (sq >= prev_i.gr.lhs) begin
          next_d.gr.gdd      = prev_i.gr.gdd + step;
          next_d.gr.lvl[BIT] = 1'b1;
        end
      end
    end
  endgenerate

  // cell register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q <= '0;
    end else begin
      next_q <= next_d;
    end
  end

  assign next_o = next_q;

endmodule

// ===== sv/point_to_depth_pixel_projector.sv =====
// ----------------------------------------------------------------------------
// point_to_depth_pixel_projector: pinhole projection of points to pixels
// Projects camera points to image pixels and maps range to a gray level.
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  point   | point_x/y/z_i, point_valid_i, frame_last_i | start_i, busy_o
//  pixel   | pixel_hit/column/row_o, gray_level_o, frame_end_o | result_valid_o
//  config  | cfg_idx_i, cfg_data_i                   | cfg_we_i
//
// one point accepted every cycle; busy_o stays low
// a point passes the front end stages, the chain of cells and the output register;
// QB = clog2(MAX_IMAGE_SIDE) + 1 quotient bits, a quotient bit, a gray bit or both per cell
// reset empties the pipeline and restores the register defaults
// results are shown for one cycle; the receiver cannot stall
module point_to_depth_pixel_projector #(
  parameter int unsigned MAX_IMAGE_SIDE = ppr_pkg::MaxImageSide
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic signed [ppr_pkg::CoordW-1:0] point_x_i,
  input  logic signed [ppr_pkg::CoordW-1:0] point_y_i,
  input  logic signed [ppr_pkg::CoordW-1:0] point_z_i,
  input  logic                             point_valid_i,
  input  logic                             frame_last_i,
  input  logic                             cfg_we_i,
  input  logic [2:0]                       cfg_idx_i,
  input  logic [ppr_pkg::CfgW-1:0]         cfg_data_i,
  output logic                             result_valid_o,
  output logic                             pixel_hit_o,
  output logic [ppr_pkg::PixW-1:0]         pixel_column_o,
  output logic [ppr_pkg::PixW-1:0]         pixel_row_o,
  output logic [ppr_pkg::PixW-1:0]         gray_level_o,
  output logic                             frame_end_o
);

  localparam int unsigned QB = $clog2(MAX_IMAGE_SIDE) + 1;
  localparam int unsigned NC = (QB > ppr_pkg::GrayW) ? QB : ppr_pkg::GrayW;

  logic [ppr_pkg::FocalW-1:0] focal_q;
  logic [ppr_pkg::SideW-1:0]  width_q, height_q, side_w, side_h;
  logic [ppr_pkg::DistW-1:0]  far_q, near_q, span;
  logic [ppr_pkg::SpanW-1:0]  span_top;
  ppr_pkg::stage_t            link [NC+1];
  ppr_pkg::stage_t            last_st;
  logic                       hitx, hity, hit;
  logic                       vld_q, hit_q, end_q;
  logic [ppr_pkg::PixW-1:0]   col_q, row_q, gray_q;

  assign busy_o = 1'b0;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q  <= ppr_pkg::FocalW'(51200);
      width_q  <= ppr_pkg::SideW'(120);
      height_q <= ppr_pkg::SideW'(120);
      far_q    <= ppr_pkg::DistW'(60293);
      near_q   <= ppr_pkg::DistW'(50463);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ppr_pkg::CFG_FOCAL:  focal_q  <= cfg_data_i[ppr_pkg::FocalW-1:0];
        ppr_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[ppr_pkg::SideW-1:0];
        ppr_pkg::CFG_HEIGHT: height_q <= cfg_data_i[ppr_pkg::SideW-1:0];
        ppr_pkg::CFG_FAR:    far_q    <= cfg_data_i[ppr_pkg::DistW-1:0];
        ppr_pkg::CFG_NEAR:   near_q   <= cfg_data_i[ppr_pkg::DistW-1:0];
        default: ;
      endcase
    end
  end

  // clamped sides and gray search constants
  always_comb begin
    side_w   = (32'(width_q) > MAX_IMAGE_SIDE) ? ppr_pkg::SideW'(MAX_IMAGE_SIDE) : width_q;
    side_h   = (32'(height_q) > MAX_IMAGE_SIDE) ? ppr_pkg::SideW'(MAX_IMAGE_SIDE) : height_q;
    span_top = ppr_pkg::SpanW'({far_q, 8'b0}) - ppr_pkg::SpanW'(far_q);
    span     = far_q - near_q;
  end

  ppr_front #(
    .QB (QB)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (start_i && !busy_o),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .point_z_i     (point_z_i),
    .point_valid_i (point_valid_i),
    .frame_last_i  (frame_last_i),
    .focal_i       (focal_q),
    .side_w_i      (side_w),
    .side_h_i      (side_h),
    .far_i         (far_q),
    .near_i        (near_q),
    .stage_o       (link[0])
  );

  // chain of cells, most significant bit first
  for (genvar i = 0; i < NC; i++) begin : g_cell
    ppr_cell #(
      .BIT (NC - 1 - i),
      .QB  (QB)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .span_top_i (span_top),
      .span_i     (span),
      .prev_i     (link[i]),
      .next_o     (link[i+1])
    );
  end

  // bounds check on the rounded pixel, a negative side only rounds to zero
  always_comb begin
    last_st = link[NC];
    hitx = !last_st.ax.over && (last_st.ax.quo < ppr_pkg::QuoW'(side_w)) &&
           (!last_st.ax.neg || (last_st.ax.quo == '0));
    hity = !last_st.ay.over && (last_st.ay.quo < ppr_pkg::QuoW'(side_h)) &&
           (!last_st.ay.neg || (last_st.ay.quo == '0));
    hit  = last_st.ctrl.ok && hitx && hity;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= last_st.ctrl.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q  <= hit;
    end_q  <= last_st.ctrl.last;
    col_q  <= hit ? last_st.ax.quo[ppr_pkg::PixW-1:0] : '0;
    row_q  <= hit ? last_st.ay.quo[ppr_pkg::PixW-1:0] : '0;
    gray_q <= (hit && last_st.ctrl.inband) ? last_st.gr.lvl : '0;
  end

  assign result_valid_o = vld_q;
  assign pixel_hit_o    = hit_q;
  assign pixel_column_o = col_q;
  assign pixel_row_o    = row_q;
  assign gray_level_o   = gray_q;
  assign frame_end_o    = end_q;

endmodule
